// ===== rtl/price_level_book_update_defines.svh =====
// Assertion macros for the price level book checker.
// No dependencies; include by bare file name.
`ifndef PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH
`define PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PBLU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PBLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pblu_pkg.sv =====
// Shared types and constants for the price level book.
// No dependencies.
package pblu_pkg;

    localparam int LEVELS     = 64;
    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 32;
    localparam int FILL_W     = $clog2(LEVELS + 1);

    typedef enum logic [2:0] {
        STAT_REPLACED = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_DELETED  = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_ABSENT   = 3'd4
    } pblu_status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } pblu_state_t;

    // Broadcast from a table to every cell of its chain.
    typedef struct packed {
        logic sample;  // latch compare flags against the incoming price
        logic ins;     // open a slot at the insert point, shift up
        logic del;     // close the matching slot, shift down
        logic rep;     // overwrite the quantity of the matching slot
    } pblu_cell_ctrl_t;

endpackage

// ===== rtl/pblu_cell.sv =====
// One level slot of a sorted level table.
// Depends on pblu_pkg.
module pblu_cell
(
    input  logic                              clk,
    input  logic                              descending,
    input  logic                              valid,
    input  pblu_pkg::pblu_cell_ctrl_t         ctrl,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   cmp_price,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   new_price,
    input  logic [pblu_pkg::QTY_BITS-1:0]     new_qty,
    input  logic                              left_better,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   left_price,
    input  logic [pblu_pkg::QTY_BITS-1:0]     left_qty,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   right_price,
    input  logic [pblu_pkg::QTY_BITS-1:0]     right_qty,
    output logic                              better,
    output logic                              match,
    output logic [pblu_pkg::PRICE_BITS-1:0]   price,
    output logic [pblu_pkg::QTY_BITS-1:0]     qty
);

    logic                              better_reg;
    logic                              better_next;
    logic                              match_reg;
    logic                              match_next;
    logic [pblu_pkg::PRICE_BITS-1:0]   price_reg;
    logic [pblu_pkg::PRICE_BITS-1:0]   price_next;
    logic [pblu_pkg::QTY_BITS-1:0]     qty_reg;
    logic [pblu_pkg::QTY_BITS-1:0]     qty_next;

    always_comb
    begin
        better_next = better_reg;
        match_next  = match_reg;
        price_next  = price_reg;
        qty_next    = qty_reg;
        if (ctrl.sample)
        begin
            better_next = valid && (descending ? (price_reg > cmp_price)
                                               : (price_reg < cmp_price));
            match_next  = valid && (price_reg == cmp_price);
        end
        // Slots ahead of the update point hold; the rest shift.
        if (ctrl.ins && !better_reg)
        begin
            if (left_better)
            begin
                price_next = new_price;
                qty_next   = new_qty;
            end
            else
            begin
                price_next = left_price;
                qty_next   = left_qty;
            end
        end
        if (ctrl.del && !better_reg)
        begin
            price_next = right_price;
            qty_next   = right_qty;
        end
        if (ctrl.rep && match_reg)
        begin
            qty_next = new_qty;
        end
    end

    always_ff @(posedge clk)
    begin
        better_reg <= better_next;
        match_reg  <= match_next;
        price_reg  <= price_next;
        qty_reg    <= qty_next;
    end

    assign better = better_reg;
    assign match  = match_reg;
    assign price  = price_reg;
    assign qty    = qty_reg;

endmodule

// ===== rtl/pblu_table.sv =====
// One side of the book: a chain of level cells plus the fill count.
// Depends on pblu_pkg and pblu_cell.
module pblu_table
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              descending,
    input  logic                              sample,
    input  logic                              apply,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   cmp_price,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   new_price,
    input  logic [pblu_pkg::QTY_BITS-1:0]     new_qty,
    output logic                              top_valid,
    output logic [pblu_pkg::PRICE_BITS-1:0]   top_price,
    output logic [pblu_pkg::QTY_BITS-1:0]     top_qty,
    output pblu_pkg::pblu_status_t            status
);

    localparam int N = pblu_pkg::LEVELS;

    logic [pblu_pkg::FILL_W-1:0]     fill_reg;
    logic [pblu_pkg::FILL_W-1:0]     fill_next;
    logic [N-1:0]                    cell_valid;
    logic [N-1:0]                    cell_better;
    logic [N-1:0]                    cell_match;
    logic [pblu_pkg::PRICE_BITS-1:0] cell_price [N];
    logic [pblu_pkg::QTY_BITS-1:0]   cell_qty   [N];
    pblu_pkg::pblu_cell_ctrl_t       ctrl;
    logic                            hit;
    logic                            full;
    logic                            qty_zero;

    assign hit      = |cell_match;
    assign full     = (fill_reg == pblu_pkg::FILL_W'(N));
    assign qty_zero = (new_qty == '0);

    assign ctrl.sample = sample;
    assign ctrl.ins    = apply && !qty_zero && !hit && !full;
    assign ctrl.del    = apply && qty_zero && hit;
    assign ctrl.rep    = apply && !qty_zero && hit;

    always_comb
    begin
        if (qty_zero)
        begin
            status = hit ? pblu_pkg::STAT_DELETED : pblu_pkg::STAT_ABSENT;
        end
        else if (hit)
        begin
            status = pblu_pkg::STAT_REPLACED;
        end
        else if (full)
        begin
            status = pblu_pkg::STAT_FULL;
        end
        else
        begin
            status = pblu_pkg::STAT_INSERTED;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.ins)
        begin
            fill_next = fill_reg + pblu_pkg::FILL_W'(1);
        end
        else if (ctrl.del)
        begin
            fill_next = fill_reg - pblu_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            logic                            lb;
            logic [pblu_pkg::PRICE_BITS-1:0] lp;
            logic [pblu_pkg::QTY_BITS-1:0]   lq;
            logic [pblu_pkg::PRICE_BITS-1:0] rp;
            logic [pblu_pkg::QTY_BITS-1:0]   rq;

            assign cell_valid[i] = (pblu_pkg::FILL_W'(i) < fill_reg);

            // The head cell sees a boundary on its left, the tail holds itself.
            if (i == 0)
            begin : g_head
                assign lb = 1'b1;
                assign lp = cell_price[i];
                assign lq = cell_qty[i];
            end
            else
            begin : g_body
                assign lb = cell_better[i-1];
                assign lp = cell_price[i-1];
                assign lq = cell_qty[i-1];
            end
            if (i == N - 1)
            begin : g_tail
                assign rp = cell_price[i];
                assign rq = cell_qty[i];
            end
            else
            begin : g_next
                assign rp = cell_price[i+1];
                assign rq = cell_qty[i+1];
            end

            pblu_cell u_cell
            (
                .clk         (clk),
                .descending  (descending),
                .valid       (cell_valid[i]),
                .ctrl        (ctrl),
                .cmp_price   (cmp_price),
                .new_price   (new_price),
                .new_qty     (new_qty),
                .left_better (lb),
                .left_price  (lp),
                .left_qty    (lq),
                .right_price (rp),
                .right_qty   (rq),
                .better      (cell_better[i]),
                .match       (cell_match[i]),
                .price       (cell_price[i]),
                .qty         (cell_qty[i])
            );
        end
    endgenerate

    // Best level always sits in the head cell.
    assign top_valid = (fill_reg != '0);
    assign top_price = top_valid ? cell_price[0] : '0;
    assign top_qty   = top_valid ? cell_qty[0]   : '0;

endmodule

// ===== rtl/price_level_book_update.sv =====
// Top level of the price level book: command front end and two level tables.
// Depends on pblu_pkg, pblu_table (and through it pblu_cell).
//
//  Channel   Handshake            Beat taken when          Fields
//  --------  -------------------  -----------------------  ------------------------------
//  update    start / busy         start && !busy at edge   side, price, quantity
//  result    done (strobe)        edge ending done cycle   status, best_bid_*, best_ask_*
//
// For every accepted update, the accept edge samples every cell's compare
// flags against the incoming price, the next edge applies the insert, delete
// or replace shift across the cell chain, and done is high for one cycle.
// busy is high only in the apply cycle, so a new beat can be taken at the edge
// that ends the done cycle. Reset (rst_n low) empties both tables by clearing
// the fill counts; cell contents are never cleared. The receiver cannot stall.
module price_level_book_update
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              side,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   price,
    input  logic [pblu_pkg::QTY_BITS-1:0]     quantity,
    output logic                              done,
    output logic [2:0]                        status,
    output logic                              best_bid_valid,
    output logic [pblu_pkg::PRICE_BITS-1:0]   best_bid_price,
    output logic [pblu_pkg::QTY_BITS-1:0]     best_bid_quantity,
    output logic                              best_ask_valid,
    output logic [pblu_pkg::PRICE_BITS-1:0]   best_ask_price,
    output logic [pblu_pkg::QTY_BITS-1:0]     best_ask_quantity
);

    pblu_pkg::pblu_state_t            state_reg;
    pblu_pkg::pblu_state_t            state_next;
    logic                             done_reg;
    logic                             done_next;
    pblu_pkg::pblu_status_t           status_reg;
    pblu_pkg::pblu_status_t           status_next;
    logic                             side_reg;
    logic [pblu_pkg::PRICE_BITS-1:0]  price_reg;
    logic [pblu_pkg::QTY_BITS-1:0]    qty_reg;

    logic                             accept;
    logic                             applying;
    pblu_pkg::pblu_status_t           bid_status;
    pblu_pkg::pblu_status_t           ask_status;

    assign busy     = (state_reg == pblu_pkg::S_APPLY);
    assign accept   = start && !busy;
    assign applying = (state_reg == pblu_pkg::S_APPLY);

    // Advance to apply on an accepted beat, always return to idle after.
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        case (state_reg)
            pblu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = pblu_pkg::S_APPLY;
                end
            end
            pblu_pkg::S_APPLY:
            begin
                state_next  = pblu_pkg::S_IDLE;
                done_next   = 1'b1;
                status_next = side_reg ? ask_status : bid_status;
            end
            default:
            begin
                state_next = pblu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pblu_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the command for the apply cycle; hold status for the done cycle.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
        begin
            side_reg  <= side;
            price_reg <= price;
            qty_reg   <= quantity;
        end
    end

    // Bids kept descending and asks ascending, so each best level is cell 0.
    pblu_table u_bid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .descending (1'b1),
        .sample     (accept && !side),
        .apply      (applying && !side_reg),
        .cmp_price  (price),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .top_valid  (best_bid_valid),
        .top_price  (best_bid_price),
        .top_qty    (best_bid_quantity),
        .status     (bid_status)
    );

    pblu_table u_ask
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .descending (1'b0),
        .sample     (accept && side),
        .apply      (applying && side_reg),
        .cmp_price  (price),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .top_valid  (best_ask_valid),
        .top_price  (best_ask_price),
        .top_qty    (best_ask_quantity),
        .status     (ask_status)
    );

    assign done   = done_reg;
    assign status = status_reg;

endmodule

// ===== rtl/pblu_checker.sv =====
// Port-level checker for the price level book, bound to the top level.
// Depends on pblu_pkg and price_level_book_update_defines.svh.
`include "price_level_book_update_defines.svh"

module pblu_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              done,
    input  logic [2:0]                        status,
    input  logic                              best_bid_valid,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   best_bid_price,
    input  logic [pblu_pkg::QTY_BITS-1:0]     best_bid_quantity,
    input  logic                              best_ask_valid,
    input  logic [pblu_pkg::PRICE_BITS-1:0]   best_ask_price
);

    `PBLU_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done,
        "accepted beat did not raise busy")
    `PBLU_ASSERT_NEXT(a_busy_done, busy, done && !busy,
        "busy cycle not followed by a result strobe")
    `PBLU_ASSERT_NOW(a_done_source, done, $past(start && !busy, 2),
        "result strobe without an accepted beat two cycles earlier")
    `PBLU_ASSERT_NOW(a_status_code, done,
        status == pblu_pkg::STAT_REPLACED || status == pblu_pkg::STAT_INSERTED ||
        status == pblu_pkg::STAT_DELETED || status == pblu_pkg::STAT_FULL ||
        status == pblu_pkg::STAT_ABSENT,
        "status code out of range")
    `PBLU_ASSERT_NOW(a_empty_zero, done && (!best_bid_valid || !best_ask_valid),
        (best_bid_valid || (best_bid_price == '0 && best_bid_quantity == '0)) &&
        (best_ask_valid || best_ask_price == '0),
        "empty side shows a nonzero level")

endmodule

bind price_level_book_update pblu_checker u_pblu_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .status            (status),
    .best_bid_valid    (best_bid_valid),
    .best_bid_price    (best_bid_price),
    .best_bid_quantity (best_bid_quantity),
    .best_ask_valid    (best_ask_valid),
    .best_ask_price    (best_ask_price)
);
